// ===== sv/wta_pkg.sv =====
// wall texel address: shared constants, register codes and types
// used by the channel interfaces, the top level and the checker
`timescale 1ns / 1ps
`default_nettype none

package wta_pkg;

    // size limits
    localparam int MAX_TEX_DIM = 1024;
    localparam int SCREEN_DIM  = 4096;

    // request and result field widths
    localparam int COL_W   = 12;
    localparam int WALL_W  = 13;
    localparam int ROW_W   = 12;
    localparam int SPAN_W  = 21;
    localparam int TEXC_W  = 10;
    localparam int INDEX_W = 20;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EDGE_TEX_LEFT  = 3'd0,
        CFG_EDGE_TEX_RIGHT = 3'd1,
        CFG_DEPTH_LEFT     = 3'd2,
        CFG_DEPTH_RIGHT    = 3'd3,
        CFG_TILE_COUNT     = 3'd4,
        CFG_TILE_AXIS      = 3'd5,
        CFG_TEX_WIDTH      = 3'd6,
        CFG_TEX_HEIGHT     = 3'd7
    } t_cfg_idx;

    // tile axis codes
    localparam logic AXIS_U = 1'b0;
    localparam logic AXIS_V = 1'b1;

    // vertical coordinate side band carried beside the horizontal divider
    typedef struct packed {
        logic        zero;
        logic        one;
        logic [20:0] num;
        logic [20:0] den;
    } t_vside;

    // one result
    typedef struct packed {
        logic [TEXC_W-1:0]  x;
        logic [TEXC_W-1:0]  y;
        logic [INDEX_W-1:0] index;
    } t_texel;

endpackage

`default_nettype wire

// ===== sv/wta_pix_if.sv =====
// pixel request channel: valid, ready and the per-pixel fields
// depends on wta_pkg for the field widths
`timescale 1ns / 1ps
`default_nettype none

interface wta_pix_if import wta_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [COL_W-1:0]         col_offset;
    logic [WALL_W-1:0]        wall_width;
    logic [ROW_W-1:0]         row;
    logic signed [SPAN_W-1:0] span_top;
    logic signed [SPAN_W-1:0] span_bottom;

    modport source (output valid, col_offset, wall_width, row, span_top, span_bottom,
                    input ready);
    modport sink (input valid, col_offset, wall_width, row, span_top, span_bottom,
                  output ready);
endinterface

`default_nettype wire

// ===== sv/wta_tex_if.sv =====
// texel address result channel: valid, ready and texel x, y, index
// depends on wta_pkg for the field widths
`timescale 1ns / 1ps
`default_nettype none

interface wta_tex_if import wta_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [TEXC_W-1:0]  texel_x;
    logic [TEXC_W-1:0]  texel_y;
    logic [INDEX_W-1:0] texel_index;

    modport source (output valid, texel_x, texel_y, texel_index, input ready);
    modport sink (input valid, texel_x, texel_y, texel_index, output ready);
endinterface

`default_nettype wire

// ===== sv/wall_texel_address.sv =====
// throughput: one request per cycle; the pipeline holds while the
// two-entry result buffer is full, which is what drops i_pix.ready
// the u divider (32 stages, one quotient bit each) and the texel x
// modulo (13 stages, two bits each) set the depth
// reset (synchronous, active low) empties the pipeline and the buffer
// and loads the register defaults
`timescale 1ns / 1ps
`default_nettype none

module wall_texel_address import wta_pkg::*; (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_we,
    input  wire [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire [CFG_DATA_W-1:0] i_cfg_data,
    wta_pix_if.sink              i_pix,
    wta_tex_if.source            o_tex
);

    localparam int UDIV_N = 32;
    localparam int VDIV_N = 16;
    localparam int MOD_N  = 13;
    localparam int NSTG   = 59;
    localparam int XS_W   = 26;

    // configuration registers
    logic signed [31:0] r_edge_tex_left;
    logic signed [31:0] r_edge_tex_right;
    logic [31:0]        r_depth_left;
    logic [31:0]        r_depth_right;
    logic [7:0]         r_tile_count;
    logic               r_tile_axis;
    logic [10:0]        r_tex_width;
    logic [10:0]        r_tex_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge_tex_left  <= 32'sd0;
            r_edge_tex_right <= 32'sd65536;
            r_depth_left     <= 32'd65536;
            r_depth_right    <= 32'd65536;
            r_tile_count     <= 8'd1;
            r_tile_axis      <= AXIS_V;
            r_tex_width      <= 11'd64;
            r_tex_height     <= 11'd64;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_EDGE_TEX_LEFT:  r_edge_tex_left  <= $signed(i_cfg_data);
                CFG_EDGE_TEX_RIGHT: r_edge_tex_right <= $signed(i_cfg_data);
                CFG_DEPTH_LEFT:     r_depth_left     <= i_cfg_data;
                CFG_DEPTH_RIGHT:    r_depth_right    <= i_cfg_data;
                CFG_TILE_COUNT:     r_tile_count     <= i_cfg_data[7:0];
                CFG_TILE_AXIS:      r_tile_axis      <= i_cfg_data[0];
                CFG_TEX_WIDTH:      r_tex_width      <= i_cfg_data[10:0];
                CFG_TEX_HEIGHT:     r_tex_height     <= i_cfg_data[10:0];
            endcase
        end
    end

    // effective tile count and texture size, and the magnitude of the left edge
    logic [7:0]  cnt;
    logic [10:0] tw;
    logic [10:0] th;
    logic [9:0]  tw_m1;
    logic [9:0]  th_m1;
    logic [31:0] abs_l;

    always_comb begin
        cnt = (r_tile_count == 8'd0) ? 8'd1 : r_tile_count;
        if (r_tex_width == 11'd0)                    tw = 11'd1;
        else if (r_tex_width > 11'(MAX_TEX_DIM))     tw = 11'(MAX_TEX_DIM);
        else                                         tw = r_tex_width;
        if (r_tex_height == 11'd0)                   th = 11'd1;
        else if (r_tex_height > 11'(MAX_TEX_DIM))    th = 11'(MAX_TEX_DIM);
        else                                         th = r_tex_height;
        tw_m1 = 10'(tw - 11'd1);
        th_m1 = 10'(th - 11'd1);
        abs_l = r_edge_tex_left[31] ? 32'(-r_edge_tex_left) : 32'(r_edge_tex_left);
    end

    // pipeline advance and valid bits
    logic            pipe_en;
    logic [NSTG-1:0] r_vld;
    logic [1:0]      r_cnt;

    assign pipe_en     = (r_cnt != 2'd2);
    assign i_pix.ready = pipe_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (pipe_en) begin
            r_vld <= {r_vld[NSTG-2:0], i_pix.valid};
        end
    end

    // stage 0: clamp column and width, vertical numerator and span
    logic [12:0]        n0_w;
    logic [12:0]        n0_c;
    logic [12:0]        r0_wc;
    logic [12:0]        r0_c;
    logic signed [22:0] r0_vn;
    logic signed [21:0] r0_vd;
    logic               r0_empty;

    always_comb begin
        n0_w = (i_pix.wall_width > 13'(SCREEN_DIM)) ? 13'(SCREEN_DIM) : i_pix.wall_width;
        n0_c = ({1'b0, i_pix.col_offset} > n0_w) ? n0_w : {1'b0, i_pix.col_offset};
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r0_wc    <= n0_w - n0_c;
            r0_c     <= n0_c;
            r0_vn    <= $signed({3'b000, i_pix.row, 8'h00})
                        - $signed({{2{i_pix.span_bottom[20]}}, i_pix.span_bottom});
            r0_vd    <= $signed({i_pix.span_top[20], i_pix.span_top})
                        - $signed({i_pix.span_bottom[20], i_pix.span_bottom});
            r0_empty <= (i_pix.span_top <= i_pix.span_bottom);
        end
    end

    // stage 1: edge weights, vertical special cases
    logic [44:0] r1_a;
    logic [44:0] r1_b;
    t_vside      n1_vs;
    t_vside      r1_vs;

    always_comb begin
        n1_vs.zero = r0_empty || (r0_vn <= 23'sd0);
        n1_vs.one  = !n1_vs.zero && (r0_vn >= $signed({r0_vd[21], r0_vd}));
        n1_vs.num  = r0_vn[20:0];
        n1_vs.den  = r0_vd[20:0];
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r1_a  <= 45'(r0_wc) * 45'(r_depth_right);
            r1_b  <= 45'(r0_c) * 45'(r_depth_left);
            r1_vs <= n1_vs;
        end
    end

    // stage 2: larger weight
    logic [44:0] r2_a;
    logic [44:0] r2_b;
    logic [44:0] r2_mx;
    t_vside      r2_vs;

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r2_a  <= r1_a;
            r2_b  <= r1_b;
            r2_mx <= (r1_a > r1_b) ? r1_a : r1_b;
            r2_vs <= r1_vs;
        end
    end

    // stage 3: bit length of the larger weight, scale-down amount
    logic [5:0]  n3_len;
    logic [3:0]  n3_sh;
    logic [44:0] r3_a;
    logic [44:0] r3_b;
    logic [3:0]  r3_sh;
    t_vside      r3_vs;

    always_comb begin
        n3_len = 6'd0;
        for (int j = 0; j < 45; j++) begin
            if (r2_mx[j]) n3_len = 6'(j + 1);
        end
        n3_sh = (n3_len > 6'd30) ? 4'(n3_len - 6'd30) : 4'd0;
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r3_a  <= r2_a;
            r3_b  <= r2_b;
            r3_sh <= n3_sh;
            r3_vs <= r2_vs;
        end
    end

    // stage 4: scaled weights and denominator
    logic [29:0] n4_as;
    logic [29:0] n4_bs;
    logic [29:0] r4_as;
    logic [29:0] r4_bs;
    logic [30:0] r4_den;
    t_vside      r4_vs;

    always_comb begin
        n4_as = 30'(r3_a >> r3_sh);
        n4_bs = 30'(r3_b >> r3_sh);
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r4_as  <= n4_as;
            r4_bs  <= n4_bs;
            r4_den <= {1'b0, n4_as} + {1'b0, n4_bs};
            r4_vs  <= r3_vs;
        end
    end

    // stage 5: weighted edge positions
    logic signed [62:0] r5_pa;
    logic signed [62:0] r5_pb;
    logic [30:0]        r5_den;
    t_vside             r5_vs;

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r5_pa  <= 63'($signed({1'b0, r4_as})) * 63'(r_edge_tex_left);
            r5_pb  <= 63'($signed({1'b0, r4_bs})) * 63'(r_edge_tex_right);
            r5_den <= r4_den;
            r5_vs  <= r4_vs;
        end
    end

    // stage 6: numerator sum
    logic signed [63:0] r6_num;
    logic [30:0]        r6_den;
    t_vside             r6_vs;

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r6_num <= 64'(r5_pa) + 64'(r5_pb);
            r6_den <= r5_den;
            r6_vs  <= r5_vs;
        end
    end

    // stage 7 and divider stages: |num| / den, one quotient bit per stage;
    // the v divider runs in the first stages beside it
    logic [30:0] r_urem [0:UDIV_N];
    logic [31:0] r_ulq  [0:UDIV_N];
    logic [30:0] r_uden [0:UDIV_N];
    logic        r_dz   [0:UDIV_N];
    t_vside      r_vs   [0:UDIV_N];
    logic [20:0] r_vrem [0:UDIV_N];
    logic [15:0] r_vq   [0:UDIV_N];

    logic [30:0] n_urem [1:UDIV_N];
    logic [31:0] n_ulq  [1:UDIV_N];
    logic [20:0] n_vrem [1:UDIV_N];
    logic [15:0] n_vq   [1:UDIV_N];
    logic [61:0] n7_mag;

    assign n7_mag = r6_num[63] ? 62'(-r6_num) : r6_num[61:0];

    always_comb begin : div_steps
        logic [31:0] t;
        logic        ge;
        logic [21:0] tv;
        logic        gev;
        for (int k = 1; k <= UDIV_N; k++) begin
            t         = {r_urem[k-1], r_ulq[k-1][31]};
            ge        = (t >= {1'b0, r_uden[k-1]});
            n_urem[k] = ge ? 31'(t - {1'b0, r_uden[k-1]}) : t[30:0];
            n_ulq[k]  = {r_ulq[k-1][30:0], ge};
            tv        = {r_vrem[k-1], 1'b0};
            gev       = (tv >= {1'b0, r_vs[k-1].den});
            if (k <= VDIV_N) begin
                n_vrem[k] = gev ? 21'(tv - {1'b0, r_vs[k-1].den}) : tv[20:0];
                n_vq[k]   = {r_vq[k-1][14:0], gev};
            end else begin
                n_vrem[k] = r_vrem[k-1];
                n_vq[k]   = r_vq[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_urem[0] <= {1'b0, n7_mag[61:32]};
            r_ulq[0]  <= n7_mag[31:0];
            r_uden[0] <= r6_den;
            r_dz[0]   <= (r6_den == 31'd0);
            r_vs[0]   <= r6_vs;
            r_vrem[0] <= r6_vs.num;
            r_vq[0]   <= 16'd0;
            for (int k = 1; k <= UDIV_N; k++) begin
                r_urem[k] <= n_urem[k];
                r_ulq[k]  <= n_ulq[k];
                r_uden[k] <= r_uden[k-1];
                r_dz[k]   <= r_dz[k-1];
                r_vs[k]   <= r_vs[k-1];
                r_vrem[k] <= n_vrem[k];
                r_vq[k]   <= n_vq[k];
            end
        end
    end

    // stage 40: |u| and clamped v
    logic [31:0] r40_u;
    logic [16:0] r40_v;

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r40_u <= r_dz[UDIV_N] ? abs_l : r_ulq[UDIV_N];
            if (r_vs[UDIV_N].zero)     r40_v <= 17'd0;
            else if (r_vs[UDIV_N].one) r40_v <= 17'd65536;
            else                       r40_v <= {1'b0, r_vq[UDIV_N]};
        end
    end

    // stage 41: tiling along the chosen axis
    logic [39:0] n41_pu;
    logic [24:0] n41_pv;
    logic [31:0] r41_u;
    logic [16:0] r41_v;

    always_comb begin
        n41_pu = 40'(r40_u) * 40'(cnt);
        n41_pv = 25'(r40_v) * 25'(cnt);
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            if (r_tile_axis == AXIS_U) begin
                r41_u <= {16'h0000, n41_pu[15:0]};
                r41_v <= r40_v;
            end else begin
                r41_u <= r40_u;
                r41_v <= {1'b0, n41_pv[15:0]};
            end
        end
    end

    // stage 42: scale to texture size
    logic [41:0] r42_px;
    logic [26:0] r42_py;

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r42_px <= 42'(r41_u) * 42'(tw_m1);
            r42_py <= 27'(r41_v) * 27'(th_m1);
        end
    end

    // stage 43: integer x, flipped y
    logic [26:0] n43_dy;
    logic [XS_W-1:0] r43_xs;
    logic [9:0]      r43_ty;

    assign n43_dy = {1'b0, th_m1, 16'h0000} - r42_py;

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r43_xs <= r42_px[41:16];
            r43_ty <= n43_dy[25:16];
        end
    end

    // modulo stages: x mod width, two dividend bits per stage
    logic [9:0]      r_mrem [0:MOD_N];
    logic [XS_W-1:0] r_mlo  [0:MOD_N];
    logic [9:0]      r_mty  [0:MOD_N];
    logic [9:0]      n_mrem [1:MOD_N];
    logic [XS_W-1:0] n_mlo  [1:MOD_N];

    always_comb begin : mod_steps
        logic [10:0]     t;
        logic [9:0]      rem;
        logic [XS_W-1:0] lo;
        for (int k = 1; k <= MOD_N; k++) begin
            rem = r_mrem[k-1];
            lo  = r_mlo[k-1];
            for (int j = 0; j < 2; j++) begin
                t   = {rem, lo[XS_W-1]};
                lo  = {lo[XS_W-2:0], 1'b0};
                rem = (t >= tw) ? 10'(t - tw) : t[9:0];
            end
            n_mrem[k] = rem;
            n_mlo[k]  = lo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_mrem[0] <= 10'd0;
            r_mlo[0]  <= r43_xs;
            r_mty[0]  <= r43_ty;
            for (int k = 1; k <= MOD_N; k++) begin
                r_mrem[k] <= n_mrem[k];
                r_mlo[k]  <= n_mlo[k];
                r_mty[k]  <= r_mty[k-1];
            end
        end
    end

    // last stage: linear index
    logic [20:0] n57_idx;
    t_texel      r57_tex;

    assign n57_idx = 21'(r_mty[MOD_N]) * 21'(tw) + 21'(r_mrem[MOD_N]);

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r57_tex.x     <= r_mrem[MOD_N];
            r57_tex.y     <= r_mty[MOD_N];
            r57_tex.index <= n57_idx[19:0];
        end
    end

    // two-entry result buffer
    t_texel r_ob [2];
    logic   r_head;
    logic   push;
    logic   pop;
    logic   wr_sel;

    assign push   = pipe_en && r_vld[NSTG-1];
    assign pop    = o_tex.valid && o_tex.ready;
    assign wr_sel = (r_cnt == 2'd0) ? r_head : !r_head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= 2'd0;
            r_head <= 1'b0;
        end else begin
            r_cnt <= 2'(r_cnt + {1'b0, push} - {1'b0, pop});
            if (pop) r_head <= !r_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_ob[wr_sel] <= r57_tex;
    end

    assign o_tex.valid       = (r_cnt != 2'd0);
    assign o_tex.texel_x     = r_ob[r_head].x;
    assign o_tex.texel_y     = r_ob[r_head].y;
    assign o_tex.texel_index = r_ob[r_head].index;

endmodule

`default_nettype wire

// ===== sv/wta_checker.sv =====
// port checks for wall_texel_address, attached by bind
// depends on wta_pkg for the result widths
`timescale 1ns / 1ps
`default_nettype none

module wta_checker import wta_pkg::*; (
    input wire                 i_clk,
    input wire                 i_rst_n,
    input wire                 i_in_ready,
    input wire                 i_out_valid,
    input wire                 i_out_ready,
    input wire [TEXC_W-1:0]    i_texel_x,
    input wire [TEXC_W-1:0]    i_texel_y,
    input wire [INDEX_W-1:0]   i_texel_index
);

    // reset empties the result buffer
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // request side only stalls when results are waiting
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid)
        else $error("request stalled with no result waiting");

    // a taken result frees room for a new request
    a_pop_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready |=> i_in_ready)
        else $error("request still stalled after a result was taken");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_texel_x)
            && $stable(i_texel_y) && $stable(i_texel_index))
        else $error("stalled result changed");

endmodule

bind wall_texel_address wta_checker u_wta_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_ready    (i_pix.ready),
    .i_out_valid   (o_tex.valid),
    .i_out_ready   (o_tex.ready),
    .i_texel_x     (o_tex.texel_x),
    .i_texel_y     (o_tex.texel_y),
    .i_texel_index (o_tex.texel_index)
);

`default_nettype wire
